@@ rtl/cptd_pkg.sv @@
// Package for the cyclic priority task dispatcher.
// Field widths, register map constants and the priority chain link type.
// No dependencies; imported by the interfaces and every module.
package cptd_pkg;

  localparam int TICK_W    = 32;  // tick counter and deadline width
  localparam int PERIOD_W  = 32;  // period register width
  localparam int TIDX_W    = 2;   // reported task index width
  localparam int NUM_REGS  = 4;   // period registers in the map
  localparam int CFG_IDX_W = 2;   // register index width
  localparam int CFG_DATA_W = 32; // widest register

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1);

  // Link handed from one cell to the next, towards lower priority
  typedef struct packed {
    logic              taken;  // a higher priority task is already due
    logic [TIDX_W-1:0] idx;    // index of the task that claimed the poll
  } chain_t;

endpackage

@@ rtl/cptd_if.sv @@
// Handshake interfaces for the dispatcher's poll and result channels.
// Depends on cptd_pkg for the field widths.
interface cptd_in_if
  import cptd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] now_tick;
  logic              shutdown_req;

  modport source(output valid, now_tick, shutdown_req, input ready);
  modport sink(input valid, now_tick, shutdown_req, output ready);
endinterface

interface cptd_out_if
  import cptd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              task_run;
  logic [TIDX_W-1:0] task_index;
  logic              idle_run;
  logic              halt;

  modport source(output valid, task_run, task_index, idle_run, halt, input ready);
  modport sink(input valid, task_run, task_index, idle_run, halt, output ready);
endinterface

@@ rtl/cptd_cell.sv @@
// One task cell: period and deadline registers, due test and priority link.
// Depends on cptd_pkg; instantiated in a row by the dispatcher top level.
module cptd_cell
  import cptd_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TICK_W-1:0]     now_tick,
  input  logic                  step,
  input  chain_t                chain_i,
  output chain_t                chain_o
);

  localparam logic [TIDX_W-1:0] IDX_CODE = TIDX_W'(CELL_ID % 4);
  localparam bit WRITABLE = (CELL_ID < NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_IDX = CFG_IDX_W'(CELL_ID % NUM_REGS);

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [TICK_W-1:0]   deadline_r, deadline_nxt;
  logic [TICK_W-1:0]   diff;
  logic                due;
  logic                take;

  // Half-range due test: deadline reached when now - deadline is non-negative
  assign diff = now_tick - deadline_r;
  assign due  = ~diff[TICK_W-1];
  assign take = due & ~chain_i.taken;

  // Priority link to the next cell
  always_comb begin
    chain_o.taken = chain_i.taken | due;
    chain_o.idx   = take ? IDX_CODE : chain_i.idx;
  end

  // Next state for period and deadline
  always_comb begin
    period_nxt   = period_r;
    deadline_nxt = deadline_r;
    if (WRITABLE && cfg_we && (cfg_index == REG_IDX)) begin
      period_nxt = cfg_data[PERIOD_W-1:0];
    end
    if (step && take) begin
      deadline_nxt = deadline_r + period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RST;
      deadline_r <= '0;
    end else begin
      period_r   <= period_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule

@@ rtl/cyclic_priority_task_dispatcher.sv @@
// Cyclic priority task dispatcher top level.
// Depends on cptd_pkg, cptd_if (cptd_in_if, cptd_out_if) and cptd_cell.
//
// Usage:
//  - in_ch carries one scheduler poll per transaction: now_tick and
//    shutdown_req. out_ch returns exactly one result per poll: task_run,
//    task_index, idle_run and halt.
//  - The result of a poll accepted at a clock edge is registered at that
//    edge and held in the output register.
//  - Throughput is one poll per cycle while the receiver does not stall.
//    The row of task cells decides the due task and advances its deadline
//    as the poll is accepted; the next poll sees the new deadlines at once.
//  - A new poll is taken while the output register is empty or being
//    emptied in the same cycle; if the receiver stalls with a result
//    waiting, in_ch.ready drops until that result is taken.
//  - Period registers are written through cfg_we / cfg_index / cfg_data,
//    one register per cycle, with no read-back.
//  - Synchronous reset sets every period to 1, every deadline to 0, clears
//    the halted state and empties the output register. Only reset leaves
//    the halted state.
module cyclic_priority_task_dispatcher
  import cptd_pkg::*;
#(
  parameter int TASKS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cptd_in_if.sink               in_ch,
  cptd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  chain_t chain [TASKS+1];

  logic              accept;
  logic              step;
  logic              halted_r, halted_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              task_run_r, task_run_nxt;
  logic [TIDX_W-1:0] task_index_r, task_index_nxt;
  logic              idle_run_r, idle_run_nxt;
  logic              halt_r, halt_nxt;

  // Transaction handshake on the poll channel
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign step        = accept & ~halted_r;

  // Row of task cells, task 0 at the head of the chain
  assign chain[0] = '{taken: 1'b0, idx: '0};

  for (genvar g = 0; g < TASKS; g++) begin : g_cell
    cptd_cell #(
      .CELL_ID(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_we   (cfg_we),
      .cfg_index(cfg_index),
      .cfg_data (cfg_data),
      .now_tick (in_ch.now_tick),
      .step     (step),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1])
    );
  end

  // Result and halted state
  always_comb begin
    halted_nxt     = halted_r;
    out_valid_nxt  = out_valid_r;
    task_run_nxt   = task_run_r;
    task_index_nxt = task_index_r;
    idle_run_nxt   = idle_run_r;
    halt_nxt       = halt_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (halted_r) begin
        task_run_nxt   = 1'b0;
        task_index_nxt = '0;
        idle_run_nxt   = 1'b0;
        halt_nxt       = 1'b1;
      end else begin
        task_run_nxt   = chain[TASKS].taken;
        task_index_nxt = chain[TASKS].idx;
        idle_run_nxt   = ~chain[TASKS].taken & ~in_ch.shutdown_req;
        halt_nxt       = in_ch.shutdown_req;
        halted_nxt     = in_ch.shutdown_req;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    task_run_r   <= task_run_nxt;
    task_index_r <= task_index_nxt;
    idle_run_r   <= idle_run_nxt;
    halt_r       <= halt_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.task_run   = task_run_r;
  assign out_ch.task_index = task_index_r;
  assign out_ch.idle_run   = idle_run_r;
  assign out_ch.halt       = halt_r;

  // Checks
  a_run_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.task_run && out_ch.idle_run))
    else $error("task and idle dispatched together");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted state left without reset");

  a_halted_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halted_r) |=> (out_ch.valid && out_ch.halt && !out_ch.task_run
                              && !out_ch.idle_run))
    else $error("poll while halted gave a dispatch");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("poll refused with empty output register");

endmodule

@@ tb/sv/cyclic_priority_task_dispatcher_tb.sv @@
// Self-checking testbench for the cyclic priority task dispatcher.
// Depends on cptd_pkg, cptd_in_if / cptd_out_if and the dispatcher RTL.
`timescale 1ns / 100ps

module cyclic_priority_task_dispatcher_tb;
  import cptd_pkg::*;

  localparam int NUM_TASKS = 4;
  localparam logic [TICK_W-1:0] HALF_TICK_RANGE = 32'h7FFF_FFFF;

  // Period register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_TASK0,
    REG_PERIOD_TASK1,
    REG_PERIOD_TASK2,
    REG_PERIOD_TASK3
  } period_reg_t;

  // One result transaction
  typedef struct packed {
    logic              task_run;
    logic [TIDX_W-1:0] task_index;
    logic              idle_run;
    logic              halt;
  } dispatch_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cptd_in_if  in_ch ();
  cptd_out_if out_ch ();

  cyclic_priority_task_dispatcher #(
    .TASKS(NUM_TASKS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Scheduler state as the testbench sees it
  logic [PERIOD_W-1:0] period_m   [NUM_TASKS];
  logic [TICK_W-1:0]   deadline_m [NUM_TASKS];
  logic                halted_m;

  dispatch_t expected_dispatch_q[$];
  int        error_count = 0;
  bit        tx_idle_on  = 1'b1;
  bit        rx_idle_on  = 1'b1;
  int        rx_hold_len = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("cyclic_priority_task_dispatcher test failed");
    $finish;
  end

  // Dispatch decision for one poll; advances the deadline of the task run
  function automatic dispatch_t predict_dispatch(logic [TICK_W-1:0] now, logic shut);
    dispatch_t         res;
    logic [TICK_W-1:0] lag;
    res = '0;
    if (halted_m) begin
      res.halt = 1'b1;
      return res;
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      lag = now - deadline_m[i];
      if (!res.task_run && lag <= HALF_TICK_RANGE) begin
        deadline_m[i]  = deadline_m[i] + period_m[i];
        res.task_run   = 1'b1;
        res.task_index = TIDX_W'(i);
      end
    end
    if (shut) halted_m = 1'b1;
    res.idle_run = !res.task_run && !shut;
    res.halt     = halted_m;
    return res;
  endfunction

  // Result check, then prediction for the poll taken at this edge
  always @(posedge clk) begin
    dispatch_t exp_d;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_m[i]   = PERIOD_RST;
        deadline_m[i] = '0;
      end
      halted_m = 1'b0;
      expected_dispatch_q.delete();
    end else begin
      if (cfg_we === 1'b1) period_m[cfg_index] = cfg_data;
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_dispatch_q.size() == 0) begin
          $error("result transaction with no poll outstanding");
          error_count++;
        end else begin
          exp_d = expected_dispatch_q.pop_front();
          if (out_ch.task_run !== exp_d.task_run) begin
            $error("task_run: expected %0b, got %0b", exp_d.task_run, out_ch.task_run);
            error_count++;
          end
          if (out_ch.task_index !== exp_d.task_index) begin
            $error("task_index: expected %0d, got %0d", exp_d.task_index,
                   out_ch.task_index);
            error_count++;
          end
          if (out_ch.idle_run !== exp_d.idle_run) begin
            $error("idle_run: expected %0b, got %0b", exp_d.idle_run, out_ch.idle_run);
            error_count++;
          end
          if (out_ch.halt !== exp_d.halt) begin
            $error("halt: expected %0b, got %0b", exp_d.halt, out_ch.halt);
            error_count++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        expected_dispatch_q.push_back(predict_dispatch(in_ch.now_tick, in_ch.shutdown_req));
    end
  end

  // Result receiver: random stalls per transaction, or one long hold on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Offer one poll after a random gap; valid stays high if there is no gap
  task automatic send_poll(input logic [TICK_W-1:0] tick, input logic shut);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.now_tick     <= tick;
    in_ch.shutdown_req <= shut;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_dispatch_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all period registers, one per cycle
  task automatic load_periods(input logic [NUM_REGS-1:0][PERIOD_W-1:0] periods);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= period_reg_t'(i);
      cfg_data  <= periods[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly short periods, with zero and the wide extremes mixed in
  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      7:       return '0;
      8:       return '1;
      9:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      6:       return PERIOD_W'($urandom_range(9, 1000));
      default: return PERIOD_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Reset periods of 1: tasks run in priority order, then wrap boundaries
  task automatic test_reset_defaults();
    repeat (5) send_poll('0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'h8000_0000, 1'b0);
    send_poll(32'h8000_0001, 1'b0);
    send_poll(32'h8000_0002, 1'b0);
    wait_drained();
  endtask

  // Zero period starves lower tasks; largest periods push deadlines half-way round
  task automatic test_period_extremes();
    logic [NUM_REGS-1:0][PERIOD_W-1:0] p;
    p[REG_PERIOD_TASK0] = '0;
    p[REG_PERIOD_TASK1] = '1;
    p[REG_PERIOD_TASK2] = 32'h8000_0000;
    p[REG_PERIOD_TASK3] = PERIOD_RST;
    load_periods(p);
    repeat (3) send_poll(32'h8000_0003, 1'b0);
    wait_drained();
    p[REG_PERIOD_TASK0] = '1;
    p[REG_PERIOD_TASK1] = 32'h7FFF_FFFF;
    p[REG_PERIOD_TASK2] = '0;
    p[REG_PERIOD_TASK3] = 32'h8000_0000;
    load_periods(p);
    send_poll(32'h8000_0003, 1'b0);
    send_poll(32'h8000_0003, 1'b0);
    send_poll(32'h7FFF_FFFF, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll('0, 1'b0);
    wait_drained();
  endtask

  // Random periods per phase; ticks creep forward from a live deadline
  task automatic test_random_schedule(input int polls, input int phases);
    logic [NUM_REGS-1:0][PERIOD_W-1:0] p;
    logic [TICK_W-1:0]                 tick;
    for (int ph = 0; ph < phases; ph++) begin
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) p[i] = pick_period();
      load_periods(p);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      tick = deadline_m[$urandom_range(0, NUM_TASKS - 1)] - TICK_W'($urandom_range(0, 6));
      repeat (polls / phases) begin
        // occasional stray tick, the running tick resumes afterwards
        if ($urandom_range(0, 19) == 0) begin
          send_poll(TICK_W'($urandom), 1'b0);
        end else begin
          tick = tick + TICK_W'($urandom_range(0, 3));
          send_poll(tick, 1'b0);
        end
      end
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off while polls keep coming, then the sender waits for all
  task automatic test_backpressure();
    logic [TICK_W-1:0] tick;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    tick        = deadline_m[0];
    rx_hold_len = 40;
    repeat (20) begin
      tick = tick + TICK_W'($urandom_range(0, 2));
      send_poll(tick, 1'b0);
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Shutdown latches halt; later polls do nothing, whatever they carry
  task automatic test_shutdown();
    logic [TICK_W-1:0] tick;
    tick = deadline_m[0];
    send_poll(tick, 1'b0);
    wait_drained();
    tick = ($urandom_range(0, 1) == 0) ? deadline_m[0] : deadline_m[0] + 32'h8000_0000;
    send_poll(tick, 1'b1);
    send_poll(deadline_m[1], 1'b1);
    send_poll('0, 1'b0);
    repeat (4) send_poll(TICK_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Test sequence
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.now_tick     <= '0;
    in_ch.shutdown_req <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_PERIOD_TASK0;
    cfg_data           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_period_extremes();
    test_random_schedule(600, 8);
    test_backpressure();
    test_shutdown();
    wait_drained();

    if (error_count == 0) begin
      $display("cyclic_priority_task_dispatcher test passed");
    end else begin
      $display("cyclic_priority_task_dispatcher test failed");
    end
    $finish;
  end

endmodule
